FILE: rtl/core/terminal_line_buffer_macros.svh
// Assertion macros for the terminal line buffer.
`ifndef TERMINAL_LINE_BUFFER_MACROS_SVH
`define TERMINAL_LINE_BUFFER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while reset is active.
`define TLB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("terminal_line_buffer: assertion failed");
// Next-cycle implication, sampled on clk, off while reset is active.
`define TLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("terminal_line_buffer: assertion failed");
`else
`define TLB_ASSERT_NOW(lbl, ante, cons)
`define TLB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/tlb_pkg.sv
// Types, character codes and classifiers for the terminal line buffer.
`timescale 1ns / 1ps

package tlb_pkg;

    typedef enum logic [1:0] {
        ACT_DROP  = 2'd0,
        ACT_STORE = 2'd1,
        ACT_BREAK = 2'd2
    } action_t;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z);
    endfunction

    function automatic logic is_break(input logic [7:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic is_print(input logic [7:0] b);
        return (b >= CH_SPACE) && (b <= CH_TILDE);
    endfunction

endpackage

FILE: rtl/core/tlb_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module tlb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/terminal_line_buffer.sv
// Terminal line buffer: escape filter, log pass-through and ring text store.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+--------------------------------------------
//   in      | in  | in_valid/in_stall | rx_byte
//   out     | out | out_valid/out_stall | action, log_valid, log_byte, cursor_row,
//           |     |                   | cursor_col, scrolled, stored_char
//
// One transaction per cycle sustained while out_stall is low; a byte is taken into
// p1 as the classify stage writes the text store, and as p1 advances the character is
// read back out of the store's registered port alongside the output register.
// Reset clears cursor, ring base, line length and escape state; the store needs
// no clearing pass since only written entries ever reach stored_char.
// An output stall holds the output register and backs up into in_stall.
`timescale 1ns / 1ps
`include "terminal_line_buffer_macros.svh"

module terminal_line_buffer #(
    parameter int SCREEN_LINES = 20,
    parameter int LINE_COLUMNS = 21
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] action,
    output logic       log_valid,
    output logic [7:0] log_byte,
    output logic [4:0] cursor_row,
    output logic [4:0] cursor_col,
    output logic       scrolled,
    output logic [6:0] stored_char
);

    localparam int RW    = $clog2(SCREEN_LINES);
    localparam int RW1   = RW + 1;
    localparam int CW    = $clog2(LINE_COLUMNS + 1);
    localparam int DEPTH = SCREEN_LINES * LINE_COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [RW-1:0]  LAST_ROW = RW'(SCREEN_LINES - 1);
    localparam logic [RW1-1:0] LINES_W  = RW1'(SCREEN_LINES);
    localparam logic [CW-1:0]  COLS_W   = CW'(LINE_COLUMNS);
    localparam logic [AW-1:0]  COLS_A   = AW'(LINE_COLUMNS);

    typedef struct packed {
        tlb_pkg::action_t act;
        logic             log_v;
        logic [7:0]       log_b;
        logic [RW-1:0]    row;
        logic [CW-1:0]    col;
        logic             scr;
    } stage_t;

    // architectural state
    logic          esc_reg, esc_next;
    logic [7:0]    prev_reg;
    logic [RW-1:0] row_reg, row_next;
    logic [RW-1:0] base_reg, base_next;
    logic [CW-1:0] len_reg, len_next;

    // pipeline
    logic          p1_valid_reg;
    stage_t        p1_reg, p1_next;
    logic [AW-1:0] p1_addr_reg;
    logic          p2_valid_reg;
    stage_t        p2_reg;

    logic          in_acc;
    logic          p1_adv;
    logic          p2_free;

    logic          brk;
    logic          new_line;
    logic [RW1-1:0] phys_sum;
    logic [RW-1:0] phys;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [6:0]    rd_char;

    assign p2_free  = !p2_valid_reg || !out_stall;
    assign p1_adv   = p1_valid_reg && p2_free;
    assign in_stall = p1_valid_reg && !p2_free;
    assign in_acc   = in_valid && !in_stall;

    // classify the byte and work out the cursor move
    always_comb
    begin
        brk       = tlb_pkg::is_break(rx_byte);
        new_line  = 1'b0;
        esc_next  = esc_reg;
        row_next  = row_reg;
        base_next = base_reg;
        len_next  = len_reg;
        p1_next.act   = tlb_pkg::ACT_DROP;
        p1_next.log_v = 1'b0;
        p1_next.log_b = 8'd0;
        p1_next.scr   = 1'b0;

        priority if (esc_reg)
        begin
            if (tlb_pkg::is_letter(rx_byte))
            begin
                esc_next = 1'b0;
            end
        end
        else if (rx_byte == tlb_pkg::CH_LBRK && prev_reg == tlb_pkg::CH_ESC)
        begin
            esc_next = 1'b1;
        end
        else if (tlb_pkg::is_print(rx_byte) || brk)
        begin
            p1_next.log_v = 1'b1;
            p1_next.log_b = rx_byte;
            // a full line always wraps; only the first break of a run wraps
            new_line = (len_reg == COLS_W) || (brk && !tlb_pkg::is_break(prev_reg));
            if (new_line)
            begin
                len_next = '0;
                if (row_reg != LAST_ROW)
                begin
                    row_next = row_reg + RW'(1);
                end
                else
                begin
                    base_next   = (base_reg == LAST_ROW) ? '0 : base_reg + RW'(1);
                    p1_next.scr = 1'b1;
                end
            end
            if (brk)
            begin
                p1_next.act = tlb_pkg::ACT_BREAK;
            end
            else
            begin
                p1_next.act = tlb_pkg::ACT_STORE;
            end
        end
        else
        begin
            p1_next.act = tlb_pkg::ACT_DROP;
        end

        phys_sum = {1'b0, base_next} + {1'b0, row_next};
        phys     = (phys_sum >= LINES_W) ? RW'(phys_sum - LINES_W) : RW'(phys_sum);
        wr_addr  = AW'(AW'(phys) * COLS_A) + AW'(len_next);

        // the store write sees the length before this character
        if (p1_next.act == tlb_pkg::ACT_STORE)
        begin
            len_next = len_next + CW'(1);
        end

        p1_next.row = row_next;
        p1_next.col = len_next;
    end

    assign wr_en = in_acc && (p1_next.act == tlb_pkg::ACT_STORE);

    tlb_ram #(
        .WIDTH (7),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(rx_byte[6:0]),
        .rd_en  (p1_adv),
        .rd_addr(p1_addr_reg),
        .rd_data(rd_char)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg      <= 1'b0;
            prev_reg     <= 8'd0;
            row_reg      <= '0;
            base_reg     <= '0;
            len_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                esc_reg  <= esc_next;
                prev_reg <= rx_byte;
                row_reg  <= row_next;
                base_reg <= base_next;
                len_reg  <= len_next;
            end
            if (in_acc)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p2_free)
            begin
                p2_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p1_reg      <= p1_next;
            p1_addr_reg <= wr_addr;
        end
        if (p1_adv)
        begin
            p2_reg <= p1_reg;
        end
    end

    logic [RW+4:0] row_wide;
    logic [CW+4:0] col_wide;

    assign row_wide = {5'd0, p2_reg.row};
    assign col_wide = {5'd0, p2_reg.col};

    assign out_valid   = p2_valid_reg;
    assign action      = p2_reg.act;
    assign log_valid   = p2_reg.log_v;
    assign log_byte    = p2_reg.log_b;
    assign cursor_row  = row_wide[4:0];
    assign cursor_col  = col_wide[4:0];
    assign scrolled    = p2_reg.scr;
    assign stored_char = (p2_reg.act == tlb_pkg::ACT_STORE) ? rd_char : 7'd0;

    `TLB_ASSERT_NOW(a_store_len, out_valid && p2_reg.act == tlb_pkg::ACT_STORE, p2_reg.col != '0)
    `TLB_ASSERT_NOW(a_scroll_row, out_valid && p2_reg.scr, p2_reg.row == LAST_ROW)
    `TLB_ASSERT_NEXT(a_esc_swallow, in_acc && esc_reg, p1_reg.act == tlb_pkg::ACT_DROP && !p1_reg.log_v)
    `TLB_ASSERT_NEXT(a_p1_hold, p1_valid_reg && !p1_adv, p1_valid_reg)

endmodule

FILE: test/tb.sv
// Self-checking testbench for the terminal line buffer.
`timescale 1ns / 1ps

module tb;

    localparam int ROWS = 20;
    localparam int COLS = 21;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        tlb_pkg::action_t act;
        logic             lv;
        logic [7:0]       lb;
        logic [4:0]       row;
        logic [4:0]       col;
        logic             sc;
        logic [6:0]       ch;
    } term_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] action;
    logic       log_valid;
    logic [7:0] log_byte;
    logic [4:0] cursor_row;
    logic [4:0] cursor_col;
    logic       scrolled;
    logic [6:0] stored_char;

    // bytes waiting to be sent, and the screen results they are expected to give
    logic [7:0]   rx_pending[$];
    term_result_t screen_expected[$];

    // predictor copy of the screen state
    int         line_len[ROWS] = '{default: 0};
    int         cur_row = 0;
    int         ring_top = 0;
    logic       esc_open = 1'b0;
    logic [7:0] last_rx = 8'h00;

    int total_items;
    int n_accepted = 0;
    int n_errors = 0;
    int n_stored = 0;
    int n_breaks = 0;
    int n_scrolls = 0;
    int n_dropped = 0;
    int cycles = 0;
    int idle_left;
    int stall_left;
    logic calm;

    terminal_line_buffer #(
        .SCREEN_LINES(ROWS),
        .LINE_COLUMNS(COLS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .action(action),
        .log_valid(log_valid),
        .log_byte(log_byte),
        .cursor_row(cursor_row),
        .cursor_col(cursor_col),
        .scrolled(scrolled),
        .stored_char(stored_char)
    );

    always #2 clk = ~clk;

    // Periodic windows in which no new idle run or output stall starts.
    assign calm = (cycles % 1024) < 200;

    function automatic int pick_idle_run();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return 8'($urandom_range(tlb_pkg::CH_LC_A, tlb_pkg::CH_LC_Z));
        return 8'($urandom_range(tlb_pkg::CH_UC_A, tlb_pkg::CH_UC_Z));
    endfunction

    function automatic logic [7:0] rand_printable();
        return 8'($urandom_range(tlb_pkg::CH_SPACE, tlb_pkg::CH_TILDE));
    endfunction

    function automatic logic [7:0] rand_break();
        return $urandom_range(0, 1) ? tlb_pkg::CH_CR : tlb_pkg::CH_LF;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            rx_pending.push_back(s[i]);
    endfunction

    // Advances the screen state by one received byte and queues the expected result.
    function automatic void predict_terminal(input logic [7:0] b);
        term_result_t r;
        logic brk;
        logic prev_brk;
        logic new_line;
        logic letter;
        int phys;

        brk = (b == tlb_pkg::CH_CR) || (b == tlb_pkg::CH_LF);
        prev_brk = (last_rx == tlb_pkg::CH_CR) || (last_rx == tlb_pkg::CH_LF);
        letter = (b >= tlb_pkg::CH_LC_A && b <= tlb_pkg::CH_LC_Z) ||
                 (b >= tlb_pkg::CH_UC_A && b <= tlb_pkg::CH_UC_Z);
        r.act = tlb_pkg::ACT_DROP;
        r.lv = 1'b0;
        r.lb = 8'h00;
        r.sc = 1'b0;
        r.ch = 7'h00;

        if (esc_open)
        begin
            if (letter)
                esc_open = 1'b0;
        end
        else if (b == tlb_pkg::CH_LBRK && last_rx == tlb_pkg::CH_ESC)
        begin
            esc_open = 1'b1;
        end
        else if ((b >= tlb_pkg::CH_SPACE && b <= tlb_pkg::CH_TILDE) || brk)
        begin
            r.lv = 1'b1;
            r.lb = b;
            new_line = (line_len[(ring_top + cur_row) % ROWS] >= COLS) || (brk && !prev_brk);
            if (new_line)
            begin
                if (cur_row + 1 < ROWS)
                begin
                    cur_row++;
                end
                else
                begin
                    // bottom row: top line leaves, freed line returns cleared
                    ring_top = (ring_top + 1) % ROWS;
                    cur_row = ROWS - 1;
                    r.sc = 1'b1;
                end
                line_len[(ring_top + cur_row) % ROWS] = 0;
            end
            phys = (ring_top + cur_row) % ROWS;
            if (brk)
            begin
                r.act = tlb_pkg::ACT_BREAK;
            end
            else if (line_len[phys] < COLS)
            begin
                line_len[phys]++;
                r.act = tlb_pkg::ACT_STORE;
                r.ch = b[6:0];
            end
        end
        last_rx = b;

        r.row = cur_row[4:0];
        r.col = line_len[(ring_top + cur_row) % ROWS][4:0];
        screen_expected.push_back(r);
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            n_errors++;
        end
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
            idle_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_terminal(rx_byte);
                n_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (idle_left > 0)
                begin
                    idle_left <= idle_left - 1;
                    in_valid <= 1'b0;
                end
                else if (rx_pending.size() > 0)
                begin
                    rx_byte <= rx_pending.pop_front();
                    in_valid <= 1'b1;
                    idle_left <= calm ? 0 : pick_idle_run();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        term_result_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (screen_expected.size() == 0)
                begin
                    $display("%0t: unexpected transaction, action %0h", $time, action);
                    n_errors++;
                end
                else
                begin
                    e = screen_expected.pop_front();
                    check_field("action", e.act, action);
                    check_field("log_valid", e.lv, log_valid);
                    check_field("log_byte", e.lb, log_byte);
                    check_field("cursor_row", e.row, cursor_row);
                    check_field("cursor_col", e.col, cursor_col);
                    check_field("scrolled", e.sc, scrolled);
                    check_field("stored_char", e.ch, stored_char);
                    case (e.act)
                        tlb_pkg::ACT_STORE: n_stored++;
                        tlb_pkg::ACT_BREAK: n_breaks++;
                        default:            n_dropped++;
                    endcase
                    if (e.sc)
                        n_scrolls++;
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                stall_left <= pick_idle_run();
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("FAIL terminal_line_buffer");
            $finish;
        end
    end

    initial
    begin
        int counted;
        int len;
        int r;

        // directed: field extremes, packed breaks, escape opener and lone ESC
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(8'h7F);
        rx_pending.push_back(8'h80);
        rx_pending.push_back(tlb_pkg::CH_SPACE);
        rx_pending.push_back(tlb_pkg::CH_TILDE);
        queue_text("A");
        rx_pending.push_back(tlb_pkg::CH_CR);
        rx_pending.push_back(tlb_pkg::CH_CR);
        rx_pending.push_back(tlb_pkg::CH_LF);
        queue_text("z");
        rx_pending.push_back(tlb_pkg::CH_ESC);
        queue_text("[1;[m");     // '[' inside a sequence is swallowed
        queue_text("q");
        rx_pending.push_back(tlb_pkg::CH_ESC);
        queue_text("x");         // lone ESC drops, x is stored
        rx_pending.push_back(tlb_pkg::CH_ESC);
        rx_pending.push_back(tlb_pkg::CH_ESC);
        queue_text("[2J");
        rx_pending.push_back(tlb_pkg::CH_LF);

        // random: mostly well-formed text, breaks and escape sequences
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                len = $urandom_range(1, 12);
                repeat (len) rx_pending.push_back(rand_printable());
                counted += len;
            end
            else if (r < 45)
            begin
                // exactly one full line, then a break on the full line
                rx_pending.push_back(rand_break());
                repeat (COLS) rx_pending.push_back(rand_printable());
                rx_pending.push_back(rand_break());
                counted += COLS + 2;
            end
            else if (r < 65)
            begin
                len = $urandom_range(1, 3);
                repeat (len) rx_pending.push_back(rand_break());
                counted += len;
            end
            else if (r < 80)
            begin
                len = $urandom_range(0, 4);
                rx_pending.push_back(tlb_pkg::CH_ESC);
                rx_pending.push_back(tlb_pkg::CH_LBRK);
                repeat (len)
                    rx_pending.push_back($urandom_range(0, 5) == 0 ? 8'h3B :
                                         8'($urandom_range(8'h30, 8'h39)));
                rx_pending.push_back(rand_letter());
                counted += len + 3;
            end
            else if (r < 88)
            begin
                rx_pending.push_back(tlb_pkg::CH_ESC);
                if ($urandom_range(0, 1))
                begin
                    rx_pending.push_back(rand_byte());
                    counted += 2;
                end
                else
                begin
                    len = $urandom_range(1, 4);
                    rx_pending.push_back(tlb_pkg::CH_LBRK);
                    repeat (len) rx_pending.push_back(rand_byte());
                    counted += len + 2;
                end
            end
            else
            begin
                len = $urandom_range(1, 3);
                repeat (len) rx_pending.push_back(rand_byte());
                counted += len;
            end
        end
        total_items = rx_pending.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_accepted < total_items || screen_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes: %0d stored, %0d line breaks, %0d dropped or swallowed",
                 total_items, n_stored, n_breaks, n_dropped);
        $display("Screen scrolled %0d times; %0d mismatches", n_scrolls, n_errors);
        if (n_errors == 0)
            $display("PASS terminal_line_buffer");
        else
            $display("FAIL terminal_line_buffer");
        $finish;
    end

endmodule

FILE: terminal_line_buffer.f
+incdir+rtl/core
rtl/core/tlb_pkg.sv
rtl/core/tlb_ram.sv
rtl/core/terminal_line_buffer.sv
test/tb.sv
